// ===== rtl/tsrl_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrl_pkg: shared types and constants of the timestamped sample ring log
// Ring depth, record layout, action and status codes, pointer helpers.
// ----------------------------------------------------------------------------
package tsrl_pkg;

    localparam int DEPTH = 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int REC_W = 50;
    localparam int OCC_W = 9;
    localparam int OCC_MAX = (1 << OCC_W) - 1;

    localparam int IN_W  = 72;
    localparam int OUT_W = 64;

    typedef enum logic [1:0] {
        ACT_STORE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_ERASE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_MORE  = 2'd1,
        STAT_LAST  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MAP_NONE,
        MAP_STORE,
        MAP_CLEAR,
        MAP_ERASE
    } t_map_op;

    typedef struct packed {
        t_map_op         op;
        logic [AW-1:0]   addr;
        logic            used;
    } t_map_cmd;

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] newest_slot(input logic [AW-1:0] wp);
        return (wp == '0) ? AW'(DEPTH - 1) : wp - AW'(1);
    endfunction

endpackage

// ===== rtl/timestamped_sample_ring_log_unit.sv =====
// ----------------------------------------------------------------------------
// timestamped_sample_ring_log_unit: ring log of timestamped climate records
// Store, read-next session, delete-oldest and erase over a ring of slots.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                        | beat
//  s_axis   | in  | tvalid tready tdata[71:0] tuser | one command
//  m_axis   | out | tvalid tready tdata[63:0] tuser | one result
//
//  Store and erase pass through their own state and FINISH to the result.
//  Read walks SCAN, RDCAP and MORE, delete SCAN and DELCLR: the slot walk visits
//  one slot per cycle through the shared pointer step and flag lookup.
//  Reset clears all slot flags together; no clearing pass.
//  s_axis_tready is high only while the sequencer is idle; a result that
//  waits on m_axis_tready holds the next command in its final step.
// ----------------------------------------------------------------------------
module timestamped_sample_ring_log_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // temperature, humidity_raw, year, month, day, hour, minute, delete_count
    input  logic [tsrl_pkg::IN_W-1:0]      s_axis_tdata,
    // action
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // rec_temperature, rec_humidity, rec_year, rec_month, rec_day, rec_hour,
    // rec_minute, occupancy
    output logic [tsrl_pkg::OUT_W-1:0]     m_axis_tdata,
    // status
    output logic [1:0]                     m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STORE,
        S_ERASE,
        S_SCAN,
        S_RDCAP,
        S_MORE,
        S_DELCLR,
        S_FINISH
    } t_state;

    t_state                          r_state;
    tsrl_pkg::t_action               r_act;
    tsrl_pkg::t_status               r_status;
    logic [tsrl_pkg::REC_W-1:0]      r_wrec;
    logic [tsrl_pkg::REC_W-1:0]      r_rec;
    logic [tsrl_pkg::AW-1:0]         r_wp;
    logic [tsrl_pkg::AW-1:0]         r_rp;
    logic                            r_active;
    logic [tsrl_pkg::AW-1:0]         r_ptr;
    logic [tsrl_pkg::CW-1:0]         r_cnt;
    logic [tsrl_pkg::CW-1:0]         r_n;
    logic                            r_mvalid;
    tsrl_pkg::t_status               r_out_status;
    logic [tsrl_pkg::REC_W-1:0]      r_out_rec;
    logic [tsrl_pkg::OCC_W-1:0]      r_out_occ;

    logic                            w_accept;
    logic [tsrl_pkg::AW-1:0]         w_pnext;
    logic                            w_used_next;
    logic [tsrl_pkg::CW-1:0]         w_count;
    logic [tsrl_pkg::OCC_W-1:0]      w_occ;
    logic [tsrl_pkg::CW-1:0]         w_dcount;
    logic [tsrl_pkg::REC_W-1:0]      w_ram_q;
    logic                            w_ram_we;
    logic                            w_ram_re;
    tsrl_pkg::t_map_cmd              w_cmd;
    logic                            w_out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_pnext       = tsrl_pkg::wrap_next(r_ptr);
    assign w_out_free    = !r_mvalid || m_axis_tready;

    assign w_dcount = (32'(s_axis_tdata[68:60]) > 32'(tsrl_pkg::DEPTH))
                    ? tsrl_pkg::CW'(tsrl_pkg::DEPTH)
                    : tsrl_pkg::CW'(s_axis_tdata[68:60]);
    assign w_occ    = (32'(w_count) > 32'(tsrl_pkg::OCC_MAX))
                    ? tsrl_pkg::OCC_W'(tsrl_pkg::OCC_MAX)
                    : tsrl_pkg::OCC_W'(w_count);

    always_comb begin
        w_cmd.op   = tsrl_pkg::MAP_NONE;
        w_cmd.addr = r_ptr;
        w_cmd.used = 1'b0;
        unique case (r_state)
            S_STORE: begin
                w_cmd.op   = tsrl_pkg::MAP_STORE;
                w_cmd.addr = r_wp;
                w_cmd.used = (r_wrec[38:34] != '0);
            end
            S_ERASE: w_cmd.op = tsrl_pkg::MAP_ERASE;
            S_DELCLR: begin
                if (r_cnt != '0) begin
                    w_cmd.op = tsrl_pkg::MAP_CLEAR;
                end
            end
            default: ;
        endcase
    end

    assign w_ram_we = (r_state == S_STORE);
    assign w_ram_re = (r_state == S_SCAN) && w_used_next && (r_act == tsrl_pkg::ACT_READ);

    tsrl_ram #(
        .W(tsrl_pkg::REC_W),
        .D(tsrl_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_wrec),
        .i_re    (w_ram_re),
        .i_raddr (w_pnext),
        .o_rdata (w_ram_q)
    );

    tsrl_slot_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_lk_addr (w_pnext),
        .o_lk_used (w_used_next),
        .o_count   (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_act        <= tsrl_pkg::ACT_STORE;
            r_status     <= tsrl_pkg::STAT_DONE;
            r_wrec       <= '0;
            r_rec        <= '0;
            r_wp         <= '0;
            r_rp         <= '0;
            r_active     <= 1'b0;
            r_ptr        <= '0;
            r_cnt        <= '0;
            r_n          <= '0;
            r_mvalid     <= 1'b0;
            r_out_status <= tsrl_pkg::STAT_DONE;
            r_out_rec    <= '0;
            r_out_occ    <= '0;
        end else begin
            if (r_mvalid && m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_act    <= tsrl_pkg::t_action'(s_axis_tuser);
                        r_status <= tsrl_pkg::STAT_DONE;
                        r_rec    <= '0;
                        r_cnt    <= '0;
                        r_n      <= w_dcount;
                        r_wrec   <= {s_axis_tdata[59:33], s_axis_tdata[32:26],
                                     s_axis_tdata[15:0]};
                        unique case (tsrl_pkg::t_action'(s_axis_tuser))
                            tsrl_pkg::ACT_STORE: r_state <= S_STORE;
                            tsrl_pkg::ACT_ERASE: r_state <= S_ERASE;
                            tsrl_pkg::ACT_READ: begin
                                r_ptr    <= r_active ? r_rp : tsrl_pkg::newest_slot(r_wp);
                                r_active <= 1'b1;
                                r_state  <= S_SCAN;
                            end
                            default: begin
                                r_ptr   <= tsrl_pkg::newest_slot(r_wp);
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_STORE: begin
                    r_wp    <= tsrl_pkg::wrap_next(r_wp);
                    r_state <= S_FINISH;
                end
                S_ERASE: r_state <= S_FINISH;
                S_SCAN: begin
                    r_ptr <= w_pnext;
                    if (w_used_next) begin
                        if (r_act == tsrl_pkg::ACT_READ) begin
                            r_rp    <= w_pnext;
                            r_state <= S_RDCAP;
                        end else begin
                            r_cnt   <= r_n;
                            r_state <= S_DELCLR;
                        end
                    end else if (r_cnt == tsrl_pkg::CW'(tsrl_pkg::DEPTH - 1)) begin
                        if (r_act == tsrl_pkg::ACT_READ) begin
                            r_status <= tsrl_pkg::STAT_EMPTY;
                            r_active <= 1'b0;
                        end
                        r_state <= S_FINISH;
                    end else begin
                        r_cnt <= r_cnt + tsrl_pkg::CW'(1);
                    end
                end
                S_RDCAP: begin
                    r_rec   <= w_ram_q;
                    r_state <= S_MORE;
                end
                S_MORE: begin
                    if (r_ptr == tsrl_pkg::newest_slot(r_wp)) begin
                        r_status <= tsrl_pkg::STAT_LAST;
                        r_active <= 1'b0;
                        r_state  <= S_FINISH;
                    end else if (w_used_next) begin
                        r_status <= tsrl_pkg::STAT_MORE;
                        r_state  <= S_FINISH;
                    end else begin
                        r_ptr <= w_pnext;
                    end
                end
                S_DELCLR: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_ptr <= w_pnext;
                        r_cnt <= r_cnt - tsrl_pkg::CW'(1);
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_mvalid     <= 1'b1;
                        r_out_status <= r_status;
                        r_out_rec    <= r_rec;
                        r_out_occ    <= w_occ;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {5'd0, r_out_occ, r_out_rec};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after an accepted command");

    a_read_has_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == tsrl_pkg::STAT_MORE
                           || m_axis_tuser == tsrl_pkg::STAT_LAST))
        |-> (m_axis_tdata[38:34] != '0))
        else $error("record returned from an empty slot");

    a_empty_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == tsrl_pkg::STAT_EMPTY)
        |-> (m_axis_tdata[58:50] == '0))
        else $error("empty status with nonzero occupancy");
`endif

endmodule

// ===== rtl/tsrl_ram.sv =====
// ----------------------------------------------------------------------------
// tsrl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
module tsrl_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                  i_wdata,
    input  logic                          i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/tsrl_slot_map.sv =====
// ----------------------------------------------------------------------------
// tsrl_slot_map: per-slot occupancy flags and occupied-slot counter
// Store, clear and erase update the flags and keep the count in step.
// ----------------------------------------------------------------------------
module tsrl_slot_map (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tsrl_pkg::t_map_cmd         i_cmd,
    input  logic [tsrl_pkg::AW-1:0]    i_lk_addr,
    output logic                       o_lk_used,
    output logic [tsrl_pkg::CW-1:0]    o_count
);

    logic                     r_used [tsrl_pkg::DEPTH];
    logic [tsrl_pkg::CW-1:0]  r_count;
    logic [tsrl_pkg::CW-1:0]  n_count;
    logic                     w_cur_used;
    logic [tsrl_pkg::CW-1:0]  w_after_clr;

    assign w_cur_used  = r_used[i_cmd.addr];
    assign w_after_clr = (w_cur_used && r_count != '0) ? r_count - tsrl_pkg::CW'(1) : r_count;

    always_comb begin
        unique case (i_cmd.op)
            tsrl_pkg::MAP_STORE: n_count = w_after_clr + tsrl_pkg::CW'(i_cmd.used);
            tsrl_pkg::MAP_CLEAR: n_count = w_after_clr;
            tsrl_pkg::MAP_ERASE: n_count = '0;
            default:             n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tsrl_pkg::DEPTH; i++) begin
                r_used[i] <= 1'b0;
            end
            r_count <= '0;
        end else begin
            r_count <= n_count;
            unique case (i_cmd.op)
                tsrl_pkg::MAP_STORE: r_used[i_cmd.addr] <= i_cmd.used;
                tsrl_pkg::MAP_CLEAR: r_used[i_cmd.addr] <= 1'b0;
                tsrl_pkg::MAP_ERASE: begin
                    for (int i = 0; i < tsrl_pkg::DEPTH; i++) begin
                        r_used[i] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_lk_used = r_used[i_lk_addr];
    assign o_count   = r_count;

endmodule

// ===== bench/tb_timestamped_sample_ring_log_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamped_sample_ring_log_unit: self-checking bench of the ring log
// Drives store, read-next, delete-oldest and erase commands over the input
// stream, keeps its own copy of the ring, pointers and session flag to
// predict each result beat, and compares every beat field by field. Random
// gaps and stalls on both streams, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_timestamped_sample_ring_log_unit;
    import tsrl_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int LONG_HOLD      = 300;

    typedef struct packed {
        logic [15:0] temp;
        logic [6:0]  hum;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } t_slot;

    typedef struct {
        t_action     act;
        logic [15:0] temp;
        logic [16:0] hum_raw;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [8:0]  del_cnt;
    } t_cmd;

    typedef struct {
        t_status     status;
        t_slot       rec;
        logic [8:0]  occ;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    // temperature, humidity_raw, year, month, day, hour, minute, delete_count
    logic [IN_W-1:0]   s_axis_tdata;
    // action
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // rec_temperature, rec_humidity, rec_year, rec_month, rec_day, rec_hour,
    // rec_minute, occupancy
    logic [OUT_W-1:0]  m_axis_tdata;
    // status
    logic [1:0]        m_axis_tuser;

    t_slot             ring [DEPTH];
    logic [AW-1:0]     ring_wp;
    logic [AW-1:0]     ring_rp;
    bit                ring_session;
    int                ring_occ;
    t_result           pending_results [$];
    t_status           last_status;
    int                err_cnt;
    bit                idle_on;
    bit                long_hold_req;
    int                stall_cycles;

    timestamped_sample_ring_log_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [AW-1:0] slot_after(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] last_written_slot();
        return (ring_wp == '0) ? AW'(DEPTH - 1) : ring_wp - 1'b1;
    endfunction

    function automatic int first_used_after(input logic [AW-1:0] p);
        int i;
        for (i = 0; i < DEPTH; i++) begin
            p = slot_after(p);
            if (ring[p].day != 0) return int'(p);
        end
        return -1;
    endfunction

    function automatic void drop_slot(input logic [AW-1:0] p);
        if (ring[p].day != 0 && ring_occ > 0) ring_occ--;
        ring[p] = '0;
    endfunction

    function automatic void ring_clear_all();
        int i;
        for (i = 0; i < DEPTH; i++) ring[i] = '0;
        ring_occ = 0;
    endfunction

    function automatic t_result ring_apply(input t_cmd c);
        t_result       r;
        t_slot         s;
        int            f;
        int            n;
        int            i;
        logic [AW-1:0] p;
        logic [AW-1:0] last;
        bit            more;
        r.status = STAT_DONE;
        r.rec    = '0;
        case (c.act)
            ACT_STORE: begin
                s.temp   = c.temp;
                s.hum    = 7'(c.hum_raw / 17'd1024);
                s.year   = c.year;
                s.month  = c.month;
                s.day    = c.day;
                s.hour   = c.hour;
                s.minute = c.minute;
                drop_slot(ring_wp);
                ring[ring_wp] = s;
                if (s.day != 0) ring_occ++;
                ring_wp = slot_after(ring_wp);
            end
            ACT_READ: begin
                if (!ring_session) begin
                    ring_rp      = last_written_slot();
                    ring_session = 1'b1;
                end
                f = first_used_after(ring_rp);
                if (f < 0) begin
                    r.status     = STAT_EMPTY;
                    ring_session = 1'b0;
                end else begin
                    p       = AW'(f);
                    last    = last_written_slot();
                    more    = 1'b0;
                    ring_rp = p;
                    r.rec   = ring[p];
                    while (p != last && !more) begin
                        p = slot_after(p);
                        if (ring[p].day != 0) more = 1'b1;
                    end
                    if (more) begin
                        r.status = STAT_MORE;
                    end else begin
                        r.status     = STAT_LAST;
                        ring_session = 1'b0;
                    end
                end
            end
            ACT_DELETE: begin
                f = first_used_after(last_written_slot());
                n = (int'(c.del_cnt) > DEPTH) ? DEPTH : int'(c.del_cnt);
                if (f >= 0) begin
                    p = AW'(f);
                    for (i = 0; i < n; i++) begin
                        drop_slot(p);
                        p = slot_after(p);
                    end
                end
            end
            ACT_ERASE: begin
                ring_clear_all();
            end
        endcase
        r.occ = 9'((ring_occ > OCC_MAX) ? OCC_MAX : ring_occ);
        return r;
    endfunction

    function automatic t_cmd make_cmd(input t_action a, input logic [15:0] temp,
                                      input logic [16:0] hum, input logic [6:0] year,
                                      input logic [3:0] month, input logic [4:0] day,
                                      input logic [4:0] hour, input logic [5:0] minute,
                                      input logic [8:0] del_cnt);
        t_cmd c;
        c.act     = a;
        c.temp    = temp;
        c.hum_raw = hum;
        c.year    = year;
        c.month   = month;
        c.day     = day;
        c.hour    = hour;
        c.minute  = minute;
        c.del_cnt = del_cnt;
        return c;
    endfunction

    function automatic t_cmd rand_cmd(input t_action a);
        t_cmd c;
        int   r;
        c.act = a;
        case ($urandom_range(0, 5))
            0:       c.temp = 16'h8000;
            1:       c.temp = 16'h7fff;
            default: c.temp = 16'($urandom);
        endcase
        c.hum_raw = 17'($urandom_range(0, 131071));
        c.year    = 7'($urandom_range(0, 99));
        c.month   = 4'($urandom_range(1, 12));
        c.day     = ($urandom_range(0, 15) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
        c.hour    = 5'($urandom_range(0, 23));
        c.minute  = 6'($urandom_range(0, 59));
        r = $urandom_range(0, 19);
        if (r < 14)      c.del_cnt = 9'($urandom_range(0, 6));
        else if (r < 18) c.del_cnt = 9'($urandom_range(0, 256));
        else             c.del_cnt = 9'($urandom_range(257, 511));
        return c;
    endfunction

    task automatic send_command(input t_cmd c);
        t_result r;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.act;
        s_axis_tdata  <= {3'b000, c.del_cnt, c.minute, c.hour, c.day, c.month, c.year,
                          c.hum_raw, c.temp};
        do @(posedge i_clk); while (!s_axis_tready);
        r = ring_apply(c);
        last_status = r.status;
        pending_results.push_back(r);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic test_empty_log();
        send_command(make_cmd(ACT_READ, 16'h0, 17'd0, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 9'd0));
        send_command(make_cmd(ACT_DELETE, 16'h0, 17'd0, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 9'd5));
        send_command(make_cmd(ACT_ERASE, 16'h0, 17'd0, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 9'd0));
    endtask

    task automatic test_extreme_records();
        send_command(make_cmd(ACT_STORE, 16'h8000, 17'd0, 7'd0, 4'd1, 5'd1,
                              5'd0, 6'd0, 9'd0));
        send_command(make_cmd(ACT_STORE, 16'h7fff, 17'd131071, 7'd99, 4'd12, 5'd31,
                              5'd23, 6'd59, 9'd511));
        send_command(make_cmd(ACT_STORE, 16'h0000, 17'd1023, 7'd64, 4'd8, 5'd16,
                              5'd16, 6'd32, 9'd256));
        send_command(make_cmd(ACT_STORE, 16'hffff, 17'd1024, 7'd63, 4'd7, 5'd15,
                              5'd15, 6'd31, 9'd255));
        // day 0: written but counted as empty
        send_command(make_cmd(ACT_STORE, 16'h1234, 17'd50000, 7'd21, 4'd3, 5'd0,
                              5'd9, 6'd45, 9'd0));
        send_command(make_cmd(ACT_STORE, 16'hfe0c, 17'd70000, 7'd42, 4'd10, 5'd28,
                              5'd12, 6'd5, 9'd0));
    endtask

    task automatic test_read_session();
        int i;
        for (i = 0; i < 6; i++)
            send_command(make_cmd(ACT_READ, 16'($urandom), 17'd0, 7'd0, 4'd1, 5'd1,
                                  5'd0, 6'd0, 9'd0));
    endtask

    task automatic test_newest_slot_empty();
        int i;
        // store into an open session, newest slot stays empty
        send_command(make_cmd(ACT_STORE, 16'h0101, 17'd2048, 7'd1, 4'd2, 5'd0,
                              5'd3, 6'd4, 9'd0));
        for (i = 0; i < 4; i++)
            send_command(make_cmd(ACT_READ, 16'h0, 17'd0, 7'd0, 4'd1, 5'd1,
                                  5'd0, 6'd0, 9'd0));
    endtask

    task automatic test_delete_cases();
        send_command(make_cmd(ACT_DELETE, 16'h0, 17'd0, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 9'd0));
        send_command(make_cmd(ACT_DELETE, 16'h0, 17'd0, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 9'd2));
        send_command(make_cmd(ACT_READ, 16'h0, 17'd0, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 9'd0));
        send_command(make_cmd(ACT_DELETE, 16'h0, 17'd0, 7'd0, 4'd1, 5'd1,
                              5'd0, 6'd0, 9'd511));
        send_command(make_cmd(ACT_READ, 16'h0, 17'd0, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 9'd0));
    endtask

    task automatic test_random_mix(input int count);
        int sent;
        int kind;
        int j;
        int burst;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 39);
            if (kind < 18) begin
                burst = $urandom_range(1, 20);
                for (j = 0; j < burst; j++) send_command(rand_cmd(ACT_STORE));
                sent += burst;
            end else if (kind < 32) begin
                j = 0;
                do begin
                    send_command(rand_cmd(ACT_READ));
                    j++;
                end while (last_status == STAT_MORE && j < 30);
                sent += j;
            end else if (kind < 37) begin
                send_command(rand_cmd(ACT_DELETE));
                sent++;
            end else if (kind < 38) begin
                send_command(rand_cmd(ACT_ERASE));
                sent++;
            end else begin
                burst = $urandom_range(1, 4);
                for (j = 0; j < burst; j++)
                    send_command(rand_cmd(t_action'($urandom_range(0, 3))));
                sent += burst;
            end
        end
    endtask

    task automatic test_backpressure();
        int i;
        long_hold_req <= 1'b1;
        for (i = 0; i < 30; i++)
            send_command(rand_cmd(($urandom_range(0, 2) == 0) ? ACT_READ : ACT_STORE));
        wait_for_results();
    endtask

    task automatic test_no_idle_stream();
        idle_on <= 1'b0;
        test_random_mix(100);
    endtask

    // output stall generator
    initial begin
        int hold;
        hold = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req <= 1'b0;
                hold = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result beat, expected none, actual tuser %0d tdata %0h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("status", int'(want.status), int'(m_axis_tuser));
                check_field("rec_temperature", int'($signed(want.rec.temp)),
                            int'($signed(m_axis_tdata[15:0])));
                check_field("rec_humidity", int'(want.rec.hum), int'(m_axis_tdata[22:16]));
                check_field("rec_year", int'(want.rec.year), int'(m_axis_tdata[29:23]));
                check_field("rec_month", int'(want.rec.month), int'(m_axis_tdata[33:30]));
                check_field("rec_day", int'(want.rec.day), int'(m_axis_tdata[38:34]));
                check_field("rec_hour", int'(want.rec.hour), int'(m_axis_tdata[43:39]));
                check_field("rec_minute", int'(want.rec.minute), int'(m_axis_tdata[49:44]));
                check_field("occupancy", int'(want.occ), int'(m_axis_tdata[58:50]));
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timestamped_sample_ring_log_unit test failed");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_STORE;
        idle_on       <= 1'b1;
        long_hold_req <= 1'b0;
        err_cnt       = 0;
        ring_wp       = '0;
        ring_rp       = '0;
        ring_session  = 1'b0;
        last_status   = STAT_DONE;
        ring_clear_all();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_log();
        test_extreme_records();
        test_read_session();
        test_newest_slot_empty();
        test_delete_cases();
        wait_for_results();
        test_random_mix(720);
        test_backpressure();
        test_no_idle_stream();

        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("timestamped_sample_ring_log_unit test passed");
        end else begin
            $display("timestamped_sample_ring_log_unit test failed");
        end
        $finish;
    end

endmodule

// ===== timestamped_sample_ring_log_unit.f =====
rtl/tsrl_pkg.sv
rtl/tsrl_ram.sv
rtl/tsrl_slot_map.sv
rtl/timestamped_sample_ring_log_unit.sv
bench/tb_timestamped_sample_ring_log_unit.sv
